// ----- sv/dns_query_parser_macros.svh -----
// Assertion macros for the DNS query parser.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef DNS_QUERY_PARSER_MACROS_SVH
`define DNS_QUERY_PARSER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Condition must hold on every clock
`define DQP_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("dqp assertion failed");

// Antecedent implies consequent in the same cycle
`define DQP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dqp assertion failed");

// Antecedent implies consequent in the next cycle
`define DQP_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dqp assertion failed");

`else

`define DQP_ASSERT_ALWAYS(label, prop)
`define DQP_ASSERT_IMP(label, ante, cons)
`define DQP_ASSERT_NXT(label, ante, cons)

`endif

`endif

// ----- sv/dqp_pkg.sv -----
`timescale 1ns / 1ps

package dqp_pkg;

    // Parse phases
    typedef enum logic [2:0] {
        PH_HEADER   = 3'd0,
        PH_NAME     = 3'd1,
        PH_TYPE_HI  = 3'd2,
        PH_TYPE_LO  = 3'd3,
        PH_CLASS_HI = 3'd4,
        PH_CLASS_LO = 3'd5,
        PH_DONE     = 3'd6
    } phase_t;

    // Result kinds
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_CHAR   = 2'd1;
    localparam logic [1:0] KIND_QDONE  = 2'd2;
    localparam logic [1:0] KIND_STATUS = 2'd3;

    // Packet status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_SHORT_HDR = 2'd1;
    localparam logic [1:0] ST_RECORDS   = 2'd2;
    localparam logic [1:0] ST_BAD_NAME  = 2'd3;

    // Header byte positions that complete a field
    localparam logic [3:0] HB_ID_LO    = 4'd1;
    localparam logic [3:0] HB_FLAGS_LO = 4'd3;
    localparam logic [3:0] HB_QD_LO    = 4'd5;
    localparam logic [3:0] HB_AN_LO    = 4'd7;
    localparam logic [3:0] HB_NS_LO    = 4'd9;
    localparam logic [3:0] HB_LAST     = 4'd11;
    localparam logic [3:0] HB_COUNT    = 4'd12;

    // Flag bit positions
    localparam int FL_QR = 15;
    localparam int FL_OP_HI = 14;
    localparam int FL_OP_LO = 11;
    localparam int FL_AA = 10;
    localparam int FL_TC = 9;
    localparam int FL_RD = 8;
    localparam int FL_RA = 7;

    // Output queue geometry
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = 2;
    localparam int CNT_W      = 3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] word_a;
        logic [15:0] word_b;
        logic        query_response_bit;
        logic [3:0]  operation_code;
        logic [3:0]  response_code;
        logic [3:0]  other_flags;
        logic [15:0] question_total;
        logic [15:0] additional_total;
        logic [7:0]  name_char;
        logic [1:0]  status;
    } result_t;

    // Up to two results per byte
    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } push_t;

    function automatic result_t make_status(input logic [1:0] code);
        result_t r;
        r        = '0;
        r.kind   = KIND_STATUS;
        r.status = code;
        return r;
    endfunction

    function automatic result_t make_char(input logic [7:0] c);
        result_t r;
        r      = '0;
        r.kind = KIND_CHAR;
        if ((c >= 8'h61 && c <= 8'h7A) || c == 8'h2D)
            r.name_char = c;
        else
            r.name_char = 8'h2E;
        return r;
    endfunction

    function automatic result_t make_question(input logic [15:0] qtype,
                                              input logic [15:0] qclass);
        result_t r;
        r        = '0;
        r.kind   = KIND_QDONE;
        r.word_a = qtype;
        r.word_b = qclass;
        return r;
    endfunction

    function automatic result_t make_header(input logic [15:0] id,
                                            input logic [15:0] flags,
                                            input logic [15:0] qd,
                                            input logic [15:0] ar);
        result_t r;
        r                    = '0;
        r.kind               = KIND_HEADER;
        r.word_a             = id;
        r.word_b             = flags;
        r.query_response_bit = flags[FL_QR];
        r.operation_code     = flags[FL_OP_HI:FL_OP_LO];
        r.response_code      = flags[3:0];
        r.other_flags        = {flags[FL_AA], flags[FL_TC], flags[FL_RD], flags[FL_RA]};
        r.question_total     = qd;
        r.additional_total   = ar;
        return r;
    endfunction

endpackage

// ----- sv/dqp_parser.sv -----
`timescale 1ns / 1ps
`include "dns_query_parser_macros.svh"

module dqp_parser #(
    parameter int NAME_LIMIT = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    data_byte,
    input  logic          first_byte,
    input  logic          last_byte,
    input  logic          room,
    output dqp_pkg::push_t push
);
    import dqp_pkg::*;

    localparam int POS_W = (NAME_LIMIT > 2) ? $clog2(NAME_LIMIT) : 1;

    // Input register
    logic       byte_valid_reg;
    logic [7:0] byte_reg;
    logic       first_reg;
    logic       last_reg;
    logic       advance;

    // Parse state
    phase_t             phase_reg, phase_next;
    logic [3:0]         hcnt_reg, hcnt_next;
    logic [15:0]        id_reg, id_next;
    logic [15:0]        flags_reg, flags_next;
    logic [15:0]        qleft_reg, qleft_next;
    logic               recs_reg, recs_next;
    logic [7:0]         hold_reg, hold_next;
    logic [POS_W-1:0]   npos_reg, npos_next;
    logic [15:0]        stype_reg, stype_next;

    // Finish-question request
    logic        do_finish;
    logic [15:0] fq_a;
    logic [15:0] fq_b;
    logic        fq_last;
    logic        status_out;

    assign advance  = byte_valid_reg && room;
    assign in_ready = !byte_valid_reg || room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byte_valid_reg <= 1'b0;
        else if (in_ready)
            byte_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg  <= data_byte;
            first_reg <= first_byte;
            last_reg  <= last_byte;
        end
    end

    // One byte of parsing
    always_comb
    begin
        phase_t           ph;
        logic [3:0]       hcnt;
        logic [15:0]      id, flags, qleft, stype, qdec;
        logic             recs;
        logic [7:0]       hold;
        logic [POS_W-1:0] npos;
        logic [7:0]       c;

        c = byte_reg;
        if (first_reg)
        begin
            ph = PH_HEADER; hcnt = '0; id = '0; flags = '0; qleft = '0;
            recs = 1'b0; hold = '0; npos = '0; stype = '0;
        end
        else
        begin
            ph = phase_reg; hcnt = hcnt_reg; id = id_reg; flags = flags_reg;
            qleft = qleft_reg; recs = recs_reg; hold = hold_reg; npos = npos_reg;
            stype = stype_reg;
        end

        phase_next = ph;    hcnt_next = hcnt;   id_next = id;
        flags_next = flags; qleft_next = qleft; recs_next = recs;
        hold_next  = hold;  npos_next = npos;   stype_next = stype;

        push       = '0;
        do_finish  = 1'b0;
        fq_a       = '0;
        fq_b       = '0;
        fq_last    = last_reg;
        qdec       = '0;

        unique case (ph)
            PH_HEADER:
            begin
                if (hcnt < HB_LAST)
                begin
                    unique case (hcnt)
                        HB_ID_LO:    id_next    = {hold, c};
                        HB_FLAGS_LO: flags_next = {hold, c};
                        HB_QD_LO:    qleft_next = {hold, c};
                        HB_AN_LO, HB_NS_LO:
                        begin
                            if (hold != 8'd0 || c != 8'd0)
                                recs_next = 1'b1;
                        end
                        default:     hold_next  = c;
                    endcase
                    hcnt_next = hcnt + 4'd1;
                    if (last_reg)
                    begin
                        push.res0  = make_status(ST_SHORT_HDR);
                        push.count = 2'd1;
                        phase_next = PH_DONE;
                    end
                end
                else
                begin
                    push.res0  = make_header(id, flags, qleft, {hold, c});
                    push.count = 2'd1;
                    hcnt_next  = HB_COUNT;
                    if (recs)
                    begin
                        push.res1  = make_status(ST_RECORDS);
                        push.count = 2'd2;
                        phase_next = PH_DONE;
                    end
                    else if (qleft == 16'd0)
                    begin
                        push.res1  = make_status(ST_OK);
                        push.count = 2'd2;
                        phase_next = PH_DONE;
                    end
                    else if (last_reg)
                    begin
                        push.res1  = make_status(ST_BAD_NAME);
                        push.count = 2'd2;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        phase_next = PH_NAME;
                        npos_next  = '0;
                    end
                end
            end
            PH_NAME:
            begin
                if (npos == '0)
                begin
                    // Leading label length is skipped
                    if (last_reg)
                    begin
                        push.res0  = make_status(ST_BAD_NAME);
                        push.count = 2'd1;
                        phase_next = PH_DONE;
                    end
                    else
                        npos_next = POS_W'(1);
                end
                else if (c == 8'd0)
                begin
                    phase_next = PH_TYPE_HI;
                    do_finish  = last_reg;
                end
                else
                begin
                    push.res0  = make_char(c);
                    push.count = 2'd1;
                    if (last_reg || npos == POS_W'(NAME_LIMIT - 1))
                    begin
                        push.res1  = make_status(ST_BAD_NAME);
                        push.count = 2'd2;
                        phase_next = PH_DONE;
                    end
                    else
                        npos_next = npos + POS_W'(1);
                end
            end
            PH_TYPE_HI:
            begin
                hold_next  = c;
                phase_next = PH_TYPE_LO;
                do_finish  = last_reg;
            end
            PH_TYPE_LO:
            begin
                stype_next = {hold, c};
                phase_next = PH_CLASS_HI;
                do_finish  = last_reg;
                fq_a       = {hold, c};
            end
            PH_CLASS_HI:
            begin
                hold_next  = c;
                phase_next = PH_CLASS_LO;
                do_finish  = last_reg;
                fq_a       = stype;
            end
            PH_CLASS_LO:
            begin
                do_finish = 1'b1;
                fq_a      = stype;
                fq_b      = {hold, c};
            end
            default: ;
        endcase

        // Question done, then status or the next name
        if (do_finish)
        begin
            push.res0  = make_question(fq_a, fq_b);
            push.count = 2'd1;
            qdec       = (qleft != 16'd0) ? qleft - 16'd1 : qleft;
            qleft_next = qdec;
            stype_next = '0;
            if (qdec == 16'd0)
            begin
                push.res1  = make_status(ST_OK);
                push.count = 2'd2;
                phase_next = PH_DONE;
            end
            else if (fq_last)
            begin
                push.res1  = make_status(ST_BAD_NAME);
                push.count = 2'd2;
                phase_next = PH_DONE;
            end
            else
            begin
                phase_next = PH_NAME;
                npos_next  = '0;
            end
        end

        if (last_reg)
            phase_next = PH_DONE;

        if (!advance)
            push.count = 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            hcnt_reg  <= '0;
            id_reg    <= '0;
            flags_reg <= '0;
            qleft_reg <= '0;
            recs_reg  <= 1'b0;
            hold_reg  <= '0;
            npos_reg  <= '0;
            stype_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            hcnt_reg  <= hcnt_next;
            id_reg    <= id_next;
            flags_reg <= flags_next;
            qleft_reg <= qleft_next;
            recs_reg  <= recs_next;
            hold_reg  <= hold_next;
            npos_reg  <= npos_next;
            stype_reg <= stype_next;
        end
    end

    // A status closes the packet
    assign status_out = (push.count == 2'd1 && push.res0.kind == KIND_STATUS) ||
                        (push.count == 2'd2 && push.res1.kind == KIND_STATUS);

    `DQP_ASSERT_IMP(a_pair_ends_in_status, push.count == 2'd2, push.res1.kind == KIND_STATUS)
    `DQP_ASSERT_IMP(a_push_only_on_advance, push.count != 2'd0, advance)
    `DQP_ASSERT_NXT(a_status_closes_packet, status_out, phase_reg == PH_DONE)

endmodule

// ----- sv/dqp_out_fifo.sv -----
`timescale 1ns / 1ps
`include "dns_query_parser_macros.svh"

module dqp_out_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  dqp_pkg::push_t   push,
    output logic             room,
    output logic             out_valid,
    input  logic             out_ready,
    output dqp_pkg::result_t head
);
    import dqp_pkg::*;

    result_t          entries_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] wr_ptr_p1;
    logic             pop;

    assign wr_ptr_p1 = wr_ptr_reg + PTR_W'(1);
    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign head      = entries_reg[rd_ptr_reg];
    // Room for a full pair of results
    assign room      = (count_reg <= CNT_W'(FIFO_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            entries_reg[wr_ptr_reg] <= push.res0;
        if (push.count == 2'd2)
            entries_reg[wr_ptr_p1] <= push.res1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `DQP_ASSERT_ALWAYS(a_count_in_range, count_reg <= CNT_W'(FIFO_DEPTH))
    `DQP_ASSERT_IMP(a_push_needs_room, push.count != 2'd0, room)
    `DQP_ASSERT_ALWAYS(a_push_count_legal, push.count != 2'd3)

endmodule

// ----- sv/dns_query_parser.sv -----
`timescale 1ns / 1ps

// DNS query parser: streams one packet byte per input transfer.
// Input channel in_valid/in_ready carries data_byte with first_byte and
// last_byte framing marks; first_byte restarts parsing at header byte zero.
// Output channel out_valid/out_ready carries one result per transfer: the
// header after byte 12, one name character per label byte, a question-done
// result with type and class, and exactly one status per packet.
// A byte passes the input register, then the parse step into a four-entry
// result queue, and its results reach the output from the queue head.
// Throughput: one byte per cycle; a byte yields at most two results, and the
// input is taken whenever the input register is free or the queue has room
// for two more.
// When the receiver stalls, results wait in the queue and the input stops
// once fewer than two queue entries are free.
// Reset clears the parse state to the header phase and empties the queue;
// bytes after a status are dropped until the next first_byte.
module dns_query_parser #(
    parameter int NAME_LIMIT = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [15:0] word_a,
    output logic [15:0] word_b,
    output logic        query_response_bit,
    output logic [3:0]  operation_code,
    output logic [3:0]  response_code,
    output logic [3:0]  other_flags,
    output logic [15:0] question_total,
    output logic [15:0] additional_total,
    output logic [7:0]  name_char,
    output logic [1:0]  status
);
    import dqp_pkg::*;

    push_t   push;
    result_t head;
    logic    room;

    dqp_parser #(
        .NAME_LIMIT(NAME_LIMIT)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .first_byte (first_byte),
        .last_byte  (last_byte),
        .room       (room),
        .push       (push)
    );

    dqp_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    // Result fields from the queue head
    assign kind               = head.kind;
    assign word_a             = head.word_a;
    assign word_b             = head.word_b;
    assign query_response_bit = head.query_response_bit;
    assign operation_code     = head.operation_code;
    assign response_code      = head.response_code;
    assign other_flags        = head.other_flags;
    assign question_total     = head.question_total;
    assign additional_total   = head.additional_total;
    assign name_char          = head.name_char;
    assign status             = head.status;

endmodule
